FILE: rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types and constants for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

  // hue units per 60 degree sector and per full turn
  localparam int unsigned SectorUnits = 3840;
  localparam int unsigned FullTurn    = 23040;
  localparam int unsigned UnitMax     = 255;
  localparam int unsigned NumSectors  = 6;

  // final divide by 3840*255: a shift by 8, then a divide by 15*255
  localparam int unsigned DropBits   = 8;
  localparam int unsigned DivLow     = 3825;
  localparam int unsigned RecipShift = 32;

  // field and datapath widths
  localparam int unsigned HueW    = 15;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned SectW   = 3;
  localparam int unsigned FracW   = 12;
  localparam int unsigned ChromaW = 16;
  localparam int unsigned SumW    = 28;
  localparam int unsigned ShW     = SumW - DropBits;
  localparam int unsigned RecipW  = 21;
  localparam int unsigned ProdW   = ShW + RecipW;
  localparam int unsigned QuotW   = ProdW - RecipShift;

  // floor(2^32 / 3825), the estimate is low by at most one
  localparam logic [RecipW-1:0] RecipK =
    RecipW'((64'd1 << RecipShift) / DivLow);

  // number of color channels
  localparam int unsigned NumChan = 3;
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  // one input item
  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } in_t;

  // one result item
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Five stage pipeline that turns one HSV pixel into one 8-bit RGB pixel.
// ----------------------------------------------------------------------------
// The converter takes one pixel on every clock and returns its RGB value
// via the stage registers and the output register, for one cycle, with
// out_valid high. busy never rises, so start may be held high continuously.
// The rate is set by the pipeline itself: the multipliers (chroma, ramp,
// reciprocal) sit in separate stages and each item moves one stage per
// clock. The receiver cannot hold results off and must take each one as it
// appears. Hue values of 360 degrees or more wrap once by a full turn.
`default_nettype none

module hsv_to_rgb_converter
  import hsv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_pixel,
  output logic      out_valid,
  output out_t      out_pixel
);

  // stage valid bits
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;

  // stage 1 registers
  logic [SectW-1:0]   s1_sector_r;
  logic [FracW-1:0]   s1_frac_r;
  logic [ChromaW-1:0] s1_chroma_r;
  logic [ChanW-1:0]   s1_value_r;

  // stage 2 registers
  logic [SectW-1:0]   s2_sector_r;
  logic [SumW-1:0]    s2_ramp_r;
  logic [ChromaW-1:0] s2_chroma_r;
  logic [ChromaW-1:0] s2_offset_r;

  // stage 3, 4 and output registers
  logic [NumChan-1:0][SumW-1:0]   s3_sum_r;
  logic [NumChan-1:0][ShW-1:0]    s4_num_r;
  logic [NumChan-1:0][ProdW-1:0]  s4_prod_r;
  out_t                           out_pixel_r;

  // next values
  logic [SectW-1:0]   s1_sector_nxt;
  logic [FracW-1:0]   s1_frac_nxt;
  logic [ChromaW-1:0] s1_chroma_nxt;
  logic [SumW-1:0]    s2_ramp_nxt;
  logic [ChromaW-1:0] s2_offset_nxt;
  logic [NumChan-1:0][SumW-1:0]  s3_sum_nxt;
  logic [NumChan-1:0][ShW-1:0]   s4_num_nxt;
  logic [NumChan-1:0][ProdW-1:0] s4_prod_nxt;
  out_t               out_pixel_nxt;

  // stage 1 working signals
  logic [HueW-1:0]    hue_wrap;
  logic [HueW-1:0]    sector_base;

  // stage 2 working signals
  logic [FracW-1:0]   ramp_frac;

  // stage 3 working signals
  logic [SumW-1:0]    chroma_sc;
  logic [SumW-1:0]    offset_sc;

  // stage 5 working signals
  logic [NumChan-1:0][ChanW-1:0] chan_q;

  logic accept;

  assign accept = start && !busy;
  assign busy   = 1'b0;

  // stage 1: wrap hue, find sector and offset, chroma = s*v
  always_comb begin
    if (in_pixel.hue >= HueW'(FullTurn)) begin
      hue_wrap = in_pixel.hue - HueW'(FullTurn);
    end else begin
      hue_wrap = in_pixel.hue;
    end
    if (hue_wrap >= HueW'(5 * SectorUnits)) begin
      s1_sector_nxt = SectW'(5);
    end else if (hue_wrap >= HueW'(4 * SectorUnits)) begin
      s1_sector_nxt = SectW'(4);
    end else if (hue_wrap >= HueW'(3 * SectorUnits)) begin
      s1_sector_nxt = SectW'(3);
    end else if (hue_wrap >= HueW'(2 * SectorUnits)) begin
      s1_sector_nxt = SectW'(2);
    end else if (hue_wrap >= HueW'(SectorUnits)) begin
      s1_sector_nxt = SectW'(1);
    end else begin
      s1_sector_nxt = SectW'(0);
    end
    sector_base   = HueW'(s1_sector_nxt) * HueW'(SectorUnits);
    s1_frac_nxt   = FracW'(hue_wrap - sector_base);
    s1_chroma_nxt = ChromaW'(in_pixel.saturation) * ChromaW'(in_pixel.brightness);
  end

  // stage 2: ramp x scaled by the sector span, offset m = 255*v - c
  always_comb begin
    if (s1_sector_r[0]) begin
      ramp_frac = FracW'(SectorUnits) - s1_frac_r;
    end else begin
      ramp_frac = s1_frac_r;
    end
    s2_ramp_nxt   = SumW'(s1_chroma_r) * SumW'(ramp_frac);
    s2_offset_nxt = ChromaW'(s1_value_r) * ChromaW'(UnitMax) - s1_chroma_r;
  end

  // stage 3: route c, x and 0 to the channels and add the offset
  always_comb begin
    chroma_sc = SumW'(s2_chroma_r) * SumW'(SectorUnits);
    offset_sc = SumW'(s2_offset_r) * SumW'(SectorUnits);
    s3_sum_nxt = '0;
    unique case (s2_sector_r)
      SectW'(0): begin
        s3_sum_nxt[ChRed]   = chroma_sc;
        s3_sum_nxt[ChGreen] = s2_ramp_r;
      end
      SectW'(1): begin
        s3_sum_nxt[ChRed]   = s2_ramp_r;
        s3_sum_nxt[ChGreen] = chroma_sc;
      end
      SectW'(2): begin
        s3_sum_nxt[ChGreen] = chroma_sc;
        s3_sum_nxt[ChBlue]  = s2_ramp_r;
      end
      SectW'(3): begin
        s3_sum_nxt[ChGreen] = s2_ramp_r;
        s3_sum_nxt[ChBlue]  = chroma_sc;
      end
      SectW'(4): begin
        s3_sum_nxt[ChRed]   = s2_ramp_r;
        s3_sum_nxt[ChBlue]  = chroma_sc;
      end
      default: begin
        s3_sum_nxt[ChRed]   = chroma_sc;
        s3_sum_nxt[ChBlue]  = s2_ramp_r;
      end
    endcase
    for (int ch = 0; ch < NumChan; ch++) begin
      s3_sum_nxt[ch] = s3_sum_nxt[ch] + offset_sc;
    end
  end

  // stage 4: drop the power-of-two factor, multiply by the reciprocal
  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      s4_num_nxt[ch]  = s3_sum_r[ch][SumW-1:DropBits];
      s4_prod_nxt[ch] = ProdW'(s4_num_nxt[ch]) * ProdW'(RecipK);
    end
  end

  // stage 5: quotient estimate and one correction step
  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      logic [QuotW-1:0] q_est;
      logic [ShW-1:0]   rem;
      q_est = s4_prod_r[ch][ProdW-1:RecipShift];
      rem   = s4_num_r[ch] - ShW'(q_est) * ShW'(DivLow);
      if (rem >= ShW'(DivLow)) begin
        chan_q[ch] = ChanW'(q_est + QuotW'(1));
      end else begin
        chan_q[ch] = ChanW'(q_est);
      end
    end
    out_pixel_nxt.red   = chan_q[ChRed];
    out_pixel_nxt.green = chan_q[ChGreen];
    out_pixel_nxt.blue  = chan_q[ChBlue];
  end

  // valid bits follow the item down the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // payload registers, loaded when the stage before them holds an item
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sector_r <= s1_sector_nxt;
      s1_frac_r   <= s1_frac_nxt;
      s1_chroma_r <= s1_chroma_nxt;
      s1_value_r  <= in_pixel.brightness;
    end
    if (s1_valid_r) begin
      s2_sector_r <= s1_sector_r;
      s2_ramp_r   <= s2_ramp_nxt;
      s2_chroma_r <= s1_chroma_r;
      s2_offset_r <= s2_offset_nxt;
    end
    if (s2_valid_r) begin
      s3_sum_r <= s3_sum_nxt;
    end
    if (s3_valid_r) begin
      s4_num_r  <= s4_num_nxt;
      s4_prod_r <= s4_prod_nxt;
    end
    if (s4_valid_r) begin
      out_pixel_r <= out_pixel_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

`default_nettype wire

FILE: rtl/hsv_checker.sv
// ----------------------------------------------------------------------------
// hsv_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_checker
  import hsv_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire in_t  in_pixel,
  input wire logic out_valid,
  input wire out_t out_pixel
);

  localparam int unsigned Latency = 5;

  // the converter never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // every accepted item gives a result after the pipeline latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result missing after accepted item");

  // no result without an earlier accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##5 !out_valid)
    else $error("result without accepted item");

  // no channel exceeds the brightness of its item
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel.red   <= $past(in_pixel.brightness, Latency)) &&
                  (out_pixel.green <= $past(in_pixel.brightness, Latency)) &&
                  (out_pixel.blue  <= $past(in_pixel.brightness, Latency)))
    else $error("channel above brightness");

  // zero saturation gives a gray pixel
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_pixel.saturation, Latency) == '0)) |->
      (out_pixel.red == out_pixel.green) && (out_pixel.green == out_pixel.blue))
    else $error("unsaturated item not gray");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_pixel  (in_pixel),
  .out_valid (out_valid),
  .out_pixel (out_pixel)
);

`default_nettype wire

FILE: bench/tb_hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// Self-checking bench for the HSV to RGB pixel converter: directed corner
// pixels, then random pixels, gapped and back to back, each result checked
// against an exact fixed-point conversion computed in the bench.
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_converter;
  import hsv_pkg::*;

  // pixels expected back from the converter, oldest first
  class rgb_scoreboard;
    out_t        rgb_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // exact conversion, every term scaled by the sector width
    function out_t hsv_to_rgb(in_t px);
      logic [HueW-1:0]    hue_w;
      logic [SectW-1:0]   sect;
      logic [FracW-1:0]   frac;
      logic [ChromaW-1:0] chroma;
      logic [ChromaW-1:0] floor_lvl;
      logic [SumW-1:0]    c_s, x_s, m_s, r_s, g_s, b_s;
      out_t               rgb;
      hue_w = px.hue;
      // a hue of a full turn or more wraps once
      if (hue_w >= FullTurn) begin
        hue_w = hue_w - HueW'(FullTurn);
      end
      sect      = SectW'(hue_w / SectorUnits);
      frac      = FracW'(hue_w % SectorUnits);
      chroma    = ChromaW'(px.saturation) * ChromaW'(px.brightness);
      floor_lvl = ChromaW'(UnitMax * px.brightness - chroma);
      c_s       = SumW'(chroma * SectorUnits);
      m_s       = SumW'(floor_lvl * SectorUnits);
      // rising ramp in even sectors, falling ramp in odd ones
      if (sect[0]) begin
        x_s = SumW'(chroma * (SectorUnits - frac));
      end else begin
        x_s = SumW'(chroma * frac);
      end
      case (sect)
        3'd0: begin r_s = c_s; g_s = x_s; b_s = '0;  end
        3'd1: begin r_s = x_s; g_s = c_s; b_s = '0;  end
        3'd2: begin r_s = '0;  g_s = c_s; b_s = x_s; end
        3'd3: begin r_s = '0;  g_s = x_s; b_s = c_s; end
        3'd4: begin r_s = x_s; g_s = '0;  b_s = c_s; end
        default: begin r_s = c_s; g_s = '0;  b_s = x_s; end
      endcase
      rgb.red   = ChanW'((r_s + m_s) / (SectorUnits * UnitMax));
      rgb.green = ChanW'((g_s + m_s) / (SectorUnits * UnitMax));
      rgb.blue  = ChanW'((b_s + m_s) / (SectorUnits * UnitMax));
      return rgb;
    endfunction

    function void note_pixel(in_t px);
      rgb_q.push_back(hsv_to_rgb(px));
    endfunction

    function void check_pixel(out_t got);
      out_t want;
      if (rgb_q.size() == 0) begin
        $error("unexpected pixel r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
        errors++;
        return;
      end
      want = rgb_q.pop_front();
      if (got.red !== want.red) begin
        $error("red: expected %0d, actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, actual %0d", want.blue, got.blue);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return rgb_q.size();
    endfunction
  endclass

  localparam int unsigned HueMax    = (1 << HueW) - 1;
  localparam int unsigned StallMax  = 500;
  localparam int unsigned DrainWait = 12;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_pixel;
  logic out_valid;
  out_t out_pixel;

  rgb_scoreboard sb;
  int unsigned   stall_cnt;

  hsv_to_rgb_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_pixel (out_pixel)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // monitor: note accepted items, check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        sb.note_pixel(in_pixel);
      end
      if (out_valid) begin
        sb.check_pixel(out_pixel);
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallMax) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // random pixel that favors sector edges, wrapped hues and extreme levels
  function automatic in_t rand_pixel();
    in_t         px;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      px.hue = HueW'($urandom_range(FullTurn, HueMax));
    end else if (pick < 25) begin
      px.hue = HueW'($urandom_range(0, NumSectors) * SectorUnits + $urandom_range(0, 2));
      if ($urandom_range(0, 1) && px.hue > 1) begin
        px.hue = px.hue - HueW'(2);
      end
    end else begin
      px.hue = HueW'($urandom_range(0, FullTurn - 1));
    end
    pick = $urandom_range(0, 99);
    px.saturation = (pick < 8) ? 8'd0 : (pick < 16) ? 8'd255 : 8'($urandom);
    pick = $urandom_range(0, 99);
    px.brightness = (pick < 8) ? 8'd0 : (pick < 16) ? 8'd255 : 8'($urandom);
    return px;
  endfunction

  // drop start for the requested gap with junk on the item bus
  task automatic idle_gap(int unsigned cycles);
    start    <= 1'b0;
    in_pixel <= in_t'({$urandom, $urandom});
    repeat (cycles) @(negedge clk);
  endtask

  // present one item, wait for it to be taken; entered and left at a falling edge
  task automatic send_pixel(in_t px, bit gaps);
    bit taken;
    if (gaps && $urandom_range(0, 99) < 19) begin
      idle_gap($urandom_range(1, 2));
    end
    start    <= 1'b1;
    in_pixel <= px;
    do begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  // hold off the sender until every result is back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic send_random(int unsigned count, bit gaps);
    repeat (count) send_pixel(rand_pixel(), gaps);
  endtask

  initial begin
    in_t corner_px[$];
    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    in_pixel  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sector edges at full color, wrapped hues, gray, black, tiny levels
    corner_px = '{
      '{hue: 15'd0,     saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd1920,  saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd3839,  saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd3840,  saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd7679,  saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd7680,  saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd11519, saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd11520, saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd15359, saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd15360, saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd19199, saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd19200, saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd23039, saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd23040, saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd32767, saturation: 8'd255, brightness: 8'd255},
      '{hue: 15'd26880, saturation: 8'd200, brightness: 8'd180},
      '{hue: 15'd5000,  saturation: 8'd0,   brightness: 8'd200},
      '{hue: 15'd9000,  saturation: 8'd255, brightness: 8'd0},
      '{hue: 15'd0,     saturation: 8'd0,   brightness: 8'd0},
      '{hue: 15'd17000, saturation: 8'd255, brightness: 8'd1},
      '{hue: 15'd13000, saturation: 8'd1,   brightness: 8'd255},
      '{hue: 15'd12345, saturation: 8'd128, brightness: 8'd77},
      '{hue: 15'd21845, saturation: 8'd170, brightness: 8'd85}
    };
    foreach (corner_px[i]) send_pixel(corner_px[i], 1'b1);

    // random pixels: gapped, then a drain, then back to back, then gapped
    send_random(280, 1'b1);
    drain();
    send_random(220, 1'b0);
    send_random(250, 1'b1);

    // wait for the tail, then for any stray result
    drain();
    repeat (DrainWait) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: hsv_to_rgb_converter.f
rtl/hsv_pkg.sv
rtl/hsv_to_rgb_converter.sv
rtl/hsv_checker.sv
bench/tb_hsv_to_rgb_converter.sv
